@@ rtl/cra_pkg.sv @@
// Shared constants, types and codes of the coalescing range allocator.
`default_nettype none
package cra_pkg;

  localparam int MAX_RANGES = 32;
  localparam int IDX_W = $clog2(MAX_RANGES);
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam int CHUNK_HEADER_BYTES = 64;
  localparam int HEAD_BYTES = 64;
  // Alignment must be a power of two; rounding is done with a mask.
  localparam int ALIGN_BYTES = 16;
  localparam int ADDR_BITS = 24;
  localparam int LEN_W = ADDR_BITS + 1;
  localparam int TIME_W = 32;
  localparam int OVF_W = 40;
  localparam int REQ_W = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam int HEAD_OFF =
    ((HEAD_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam logic [LEN_W-1:0] ALIGN_MASK = ~LEN_W'(ALIGN_BYTES - 1);
  localparam logic [LEN_W-1:0] SEG_LIMIT = LEN_W'(1) << ADDR_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOL_TIME = 2'd1;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE = 2'd1;
  localparam logic [1:0] CMD_CLEAN = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0] size;
  } range_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0] size;
    logic [TIME_W-1:0] deadline;
  } cool_ent_t;

  typedef struct packed {
    logic [LEN_W-1:0] fit_len;
    logic [LEN_W-1:0] keep_len;
    logic [LEN_W-1:0] init_len;
  } sizes_t;

endpackage
`default_nettype wire

@@ rtl/coalescing_range_allocator_top.sv @@
// Top level of the coalescing range allocator: tables, sequencer and ports.
// The input channel carries one request (allocate, free, clean or a no-op) with
// in_valid/in_stall; the result channel returns exactly one result per
// request with out_valid/out_stall. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) writes segment_size (index 0) or cool_time
// (index 1); writing segment_size rebuilds all tables and totals.
// Free ranges sit in a size-sorted memory with one read and one write port;
// allocated ranges and the circular cooling FIFO share a second memory, one
// half each. Every memory read is registered, so a table step has a read state
// and a compare state. Command three changes no table and returns an OK result.
// An allocate that splits a range also scans, inserts and shifts the remainder
// into the free table, and a clean does the same for every expired range.
// One request is processed at a time; the next one can be accepted the cycle
// after its result is placed in the output register, even while that waits.
// Reset (and a segment_size write) builds the free table in an init state.
// A stalled result holds the output register and the sequencer waits at its
// final step until the register frees up.
`default_nettype none
module coalescing_range_allocator_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_command,
  input  wire logic [cra_pkg::REQ_W-1:0]        in_request_size,
  input  wire logic [cra_pkg::ADDR_BITS-1:0]    in_chunk_offset,
  input  wire logic [cra_pkg::TIME_W-1:0]       in_now,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            out_status,
  output logic [cra_pkg::ADDR_BITS-1:0]         out_range_offset,
  output logic [cra_pkg::LEN_W-1:0]             out_range_length,
  output logic [cra_pkg::LEN_W-1:0]             out_free_total,
  output logic [cra_pkg::LEN_W-1:0]             out_used_total,
  output logic [cra_pkg::LEN_W-1:0]             out_cooling_total,
  output logic [cra_pkg::OVF_W-1:0]             out_overflow_total,
  output logic [cra_pkg::TIME_W-1:0]            out_change_sequence,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cra_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [22:0] {
    S_IDLE    = 23'd1 << 0,
    S_INIT    = 23'd1 << 1,
    S_AF_RD   = 23'd1 << 2,
    S_AF_CMP  = 23'd1 << 3,
    S_A_POST  = 23'd1 << 4,
    S_A_DONE  = 23'd1 << 5,
    S_RM_CHK  = 23'd1 << 6,
    S_RM_WR   = 23'd1 << 7,
    S_P_RD    = 23'd1 << 8,
    S_P_CMP   = 23'd1 << 9,
    S_P_INS   = 23'd1 << 10,
    S_FR_RD   = 23'd1 << 11,
    S_FR_CMP  = 23'd1 << 12,
    S_SH_CHK  = 23'd1 << 13,
    S_SH_WR   = 23'd1 << 14,
    S_U_RD    = 23'd1 << 15,
    S_U_CMP   = 23'd1 << 16,
    S_U_MV_RD = 23'd1 << 17,
    S_U_MV_WR = 23'd1 << 18,
    S_C_RD    = 23'd1 << 19,
    S_C_CMP   = 23'd1 << 20,
    S_C_PUTD  = 23'd1 << 21,
    S_FIN     = 23'd1 << 22
  } state_t;

  localparam int AW = cra_pkg::ADDR_BITS;
  localparam int LW = cra_pkg::LEN_W;
  localparam int CW = cra_pkg::CNT_W;
  localparam int IW = cra_pkg::IDX_W;
  localparam int TW = cra_pkg::TIME_W;
  localparam int OW = cra_pkg::OVF_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(cra_pkg::MAX_RANGES);

  state_t state_r, rm_ret_r, put_ret_r;

  logic [LW-1:0] seg_r;
  logic [TW-1:0] cool_time_r;
  logic [cra_pkg::REQ_W-1:0] req_r;
  logic [AW-1:0] off_r;
  logic [TW-1:0] now_r;
  logic [1:0] status_r;
  logic [AW-1:0] roff_r;
  logic [LW-1:0] rlen_r;
  logic [CW-1:0] i_r, k_r;
  logic [CW-1:0] free_cnt_r, used_cnt_r, cool_cnt_r;
  logic [IW-1:0] cool_head_r;
  logic [AW-1:0] s_r, ps_r;
  logic [LW-1:0] l_r, pl_r, cl_r;
  logic put_ok_r;
  logic [LW-1:0] free_b_r, used_b_r, cool_b_r;
  logic [OW-1:0] ovf_r;
  logic [TW-1:0] seq_r;
  logic out_valid_r;

  cra_pkg::sizes_t sizes;
  logic [OW:0] ovf_sum;
  logic [LW-1:0] new_end, rd_end;
  logic out_load;

  // Free table memory.
  cra_pkg::range_t free_mem [cra_pkg::MAX_RANGES];
  cra_pkg::range_t fr_rd_r, fr_wd;
  logic fr_we;
  logic [IW-1:0] fr_wa, fr_ra;

  // Used table in the low half, cooling FIFO in the high half.
  cra_pkg::cool_ent_t ent_mem [2*cra_pkg::MAX_RANGES];
  cra_pkg::cool_ent_t ent_rd_r, ent_wd;
  logic ent_we;
  logic [IW:0] ent_wa, ent_ra;

  cra_sizes u_sizes (
    .req   (req_r),
    .seg   (seg_r),
    .sizes (sizes)
  );

  assign in_stall = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign ovf_sum = {1'b0, ovf_r} + (OW + 1)'(req_r);
  assign new_end = LW'(ps_r) + pl_r;
  assign rd_end = LW'(fr_rd_r.start) + fr_rd_r.size;

  always_comb begin
    fr_we = 1'b0;
    fr_wa = IW'(k_r);
    fr_wd = fr_rd_r;
    fr_ra = IW'(i_r);
    ent_we = 1'b0;
    ent_wa = {1'b0, IW'(i_r)};
    ent_wd = ent_rd_r;
    ent_ra = {1'b0, IW'(i_r)};
    case (state_r)
      S_INIT: begin
        fr_we = (sizes.init_len != '0);
        fr_wa = '0;
        fr_wd.start = AW'(cra_pkg::HEAD_OFF);
        fr_wd.size = sizes.init_len;
      end
      S_RM_CHK: fr_ra = IW'(k_r + CW'(1));
      S_RM_WR: fr_we = 1'b1;
      S_SH_CHK: begin
        fr_ra = IW'(k_r - CW'(1));
        if (k_r <= i_r) begin
          fr_we = 1'b1;
          fr_wa = IW'(i_r);
          fr_wd.start = ps_r;
          fr_wd.size = pl_r;
        end
      end
      S_SH_WR: fr_we = 1'b1;
      S_A_DONE: begin
        ent_we = 1'b1;
        ent_wa = {1'b0, IW'(used_cnt_r)};
        ent_wd.start = s_r;
        ent_wd.size = l_r;
      end
      S_U_CMP: begin
        ent_we = (ent_rd_r.start == off_r) && (cool_cnt_r < MAX_CNT);
        ent_wa = {1'b1, IW'(CW'(cool_head_r) + cool_cnt_r)};
        ent_wd.deadline = now_r + cool_time_r;
      end
      S_U_MV_RD: ent_ra = {1'b0, IW'(used_cnt_r - CW'(1))};
      S_U_MV_WR: ent_we = 1'b1;
      S_C_RD: ent_ra = {1'b1, cool_head_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    fr_rd_r <= free_mem[fr_ra];
    if (fr_we) begin
      free_mem[fr_wa] <= fr_wd;
    end
    ent_rd_r <= ent_mem[ent_ra];
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      rm_ret_r <= S_IDLE;
      put_ret_r <= S_IDLE;
      seg_r <= LW'(1048576);
      cool_time_r <= TW'(60);
      free_cnt_r <= '0;
      used_cnt_r <= '0;
      cool_cnt_r <= '0;
      cool_head_r <= '0;
      free_b_r <= '0;
      used_b_r <= '0;
      cool_b_r <= '0;
      ovf_r <= '0;
      seq_r <= TW'(1);
      put_ok_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == cra_pkg::CFG_SEGMENT_SIZE) begin
              seg_r <= cfg_data[LW-1:0];
              state_r <= S_INIT;
            end else if (cfg_index == cra_pkg::CFG_COOL_TIME) begin
              cool_time_r <= cfg_data[TW-1:0];
            end
          end else if (in_valid) begin
            req_r <= in_request_size;
            off_r <= in_chunk_offset;
            now_r <= in_now;
            status_r <= cra_pkg::ST_OK;
            roff_r <= '0;
            rlen_r <= '0;
            i_r <= '0;
            case (in_command)
              cra_pkg::CMD_ALLOC: begin
                if (used_cnt_r >= MAX_CNT) begin
                  status_r <= cra_pkg::ST_FULL;
                  state_r <= S_FIN;
                end else begin
                  state_r <= S_AF_RD;
                end
              end
              cra_pkg::CMD_FREE: state_r <= S_U_RD;
              cra_pkg::CMD_CLEAN: state_r <= S_C_RD;
              default: state_r <= S_FIN;
            endcase
          end
        end
        S_INIT: begin
          free_cnt_r <= (sizes.init_len != '0) ? CW'(1) : '0;
          used_cnt_r <= '0;
          cool_cnt_r <= '0;
          cool_head_r <= '0;
          free_b_r <= sizes.init_len;
          used_b_r <= '0;
          cool_b_r <= '0;
          ovf_r <= '0;
          seq_r <= TW'(1);
          state_r <= S_IDLE;
        end
        S_AF_RD: begin
          if (i_r == free_cnt_r) begin
            status_r <= cra_pkg::ST_NO_SPACE;
            ovf_r <= ovf_sum[OW] ? '1 : ovf_sum[OW-1:0];
            state_r <= S_FIN;
          end else begin
            state_r <= S_AF_CMP;
          end
        end
        S_AF_CMP: begin
          if (fr_rd_r.size >= sizes.fit_len) begin
            s_r <= fr_rd_r.start;
            l_r <= fr_rd_r.size;
            k_r <= i_r;
            rm_ret_r <= S_A_POST;
            state_r <= S_RM_CHK;
          end else begin
            i_r <= i_r + CW'(1);
            state_r <= S_AF_RD;
          end
        end
        S_A_POST: begin
          if (l_r > sizes.keep_len) begin
            // Split: the high part goes back to the free table.
            ps_r <= AW'(LW'(s_r) + sizes.fit_len);
            pl_r <= l_r - sizes.fit_len;
            l_r <= sizes.fit_len;
            i_r <= '0;
            put_ret_r <= S_A_DONE;
            state_r <= S_P_RD;
          end else begin
            state_r <= S_A_DONE;
          end
        end
        S_A_DONE: begin
          used_cnt_r <= used_cnt_r + CW'(1);
          free_b_r <= free_b_r - l_r;
          used_b_r <= used_b_r + l_r;
          seq_r <= seq_r + TW'(2);
          roff_r <= s_r;
          rlen_r <= l_r;
          state_r <= S_FIN;
        end
        S_RM_CHK: begin
          if ((k_r + CW'(1)) < free_cnt_r) begin
            state_r <= S_RM_WR;
          end else begin
            free_cnt_r <= free_cnt_r - CW'(1);
            state_r <= rm_ret_r;
          end
        end
        S_RM_WR: begin
          k_r <= k_r + CW'(1);
          state_r <= S_RM_CHK;
        end
        S_P_RD: state_r <= (i_r == free_cnt_r) ? S_P_INS : S_P_CMP;
        S_P_CMP: begin
          if (LW'(fr_rd_r.start) == new_end || LW'(ps_r) == rd_end) begin
            // A neighbor merges; remove it and rescan from the top.
            if (LW'(fr_rd_r.start) != new_end) begin
              ps_r <= fr_rd_r.start;
            end
            pl_r <= pl_r + fr_rd_r.size;
            k_r <= i_r;
            i_r <= '0;
            rm_ret_r <= S_P_RD;
            state_r <= S_RM_CHK;
          end else begin
            i_r <= i_r + CW'(1);
            state_r <= S_P_RD;
          end
        end
        S_P_INS: begin
          if (free_cnt_r >= MAX_CNT) begin
            put_ok_r <= 1'b0;
            state_r <= put_ret_r;
          end else begin
            i_r <= '0;
            state_r <= S_FR_RD;
          end
        end
        S_FR_RD: begin
          if (i_r == free_cnt_r) begin
            k_r <= free_cnt_r;
            state_r <= S_SH_CHK;
          end else begin
            state_r <= S_FR_CMP;
          end
        end
        S_FR_CMP: begin
          if (fr_rd_r.size > pl_r) begin
            k_r <= free_cnt_r;
            state_r <= S_SH_CHK;
          end else begin
            i_r <= i_r + CW'(1);
            state_r <= S_FR_RD;
          end
        end
        S_SH_CHK: begin
          if (k_r > i_r) begin
            state_r <= S_SH_WR;
          end else begin
            free_cnt_r <= free_cnt_r + CW'(1);
            put_ok_r <= 1'b1;
            state_r <= put_ret_r;
          end
        end
        S_SH_WR: begin
          k_r <= k_r - CW'(1);
          state_r <= S_SH_CHK;
        end
        S_U_RD: begin
          if (i_r == used_cnt_r) begin
            status_r <= cra_pkg::ST_NOT_FOUND;
            state_r <= S_FIN;
          end else begin
            state_r <= S_U_CMP;
          end
        end
        S_U_CMP: begin
          if (ent_rd_r.start == off_r) begin
            if (cool_cnt_r >= MAX_CNT) begin
              status_r <= cra_pkg::ST_FULL;
              state_r <= S_FIN;
            end else begin
              s_r <= ent_rd_r.start;
              l_r <= ent_rd_r.size;
              cool_cnt_r <= cool_cnt_r + CW'(1);
              state_r <= S_U_MV_RD;
            end
          end else begin
            i_r <= i_r + CW'(1);
            state_r <= S_U_RD;
          end
        end
        S_U_MV_RD: state_r <= S_U_MV_WR;
        S_U_MV_WR: begin
          used_cnt_r <= used_cnt_r - CW'(1);
          used_b_r <= used_b_r - l_r;
          cool_b_r <= cool_b_r + l_r;
          seq_r <= seq_r + TW'(2);
          rlen_r <= l_r;
          state_r <= S_FIN;
        end
        S_C_RD: state_r <= (cool_cnt_r == '0) ? S_FIN : S_C_CMP;
        S_C_CMP: begin
          if (ent_rd_r.deadline <= now_r) begin
            ps_r <= ent_rd_r.start;
            pl_r <= ent_rd_r.size;
            cl_r <= ent_rd_r.size;
            i_r <= '0;
            put_ret_r <= S_C_PUTD;
            state_r <= S_P_RD;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_C_PUTD: begin
          if (!put_ok_r) begin
            status_r <= cra_pkg::ST_FULL;
            rlen_r <= '0;
            state_r <= S_FIN;
          end else begin
            cool_head_r <= cool_head_r + IW'(1);
            cool_cnt_r <= cool_cnt_r - CW'(1);
            free_b_r <= free_b_r + cl_r;
            cool_b_r <= cool_b_r - cl_r;
            rlen_r <= rlen_r + cl_r;
            state_r <= S_C_RD;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= status_r;
      out_range_offset <= roff_r;
      out_range_length <= rlen_r;
      out_free_total <= free_b_r;
      out_used_total <= used_b_r;
      out_cooling_total <= cool_b_r;
      out_overflow_total <= ovf_r;
      out_change_sequence <= seq_r;
    end
  end

  assign out_valid = out_valid_r;

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (free_cnt_r <= MAX_CNT) && (used_cnt_r <= MAX_CNT) && (cool_cnt_r <= MAX_CNT))
    else $error("range table count beyond capacity");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted request did not start processing");

  a_sequence_odd: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r[0])
    else $error("change sequence became even");

  a_fail_no_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status != cra_pkg::ST_OK) |-> (out_range_length == '0))
    else $error("failed request reports a length");

endmodule
`default_nettype wire

@@ rtl/cra_sizes.sv @@
// Request length rounding and initial free range length of the allocator.
`default_nettype none
module cra_sizes (
  input  wire logic [cra_pkg::REQ_W-1:0] req,
  input  wire logic [cra_pkg::LEN_W-1:0] seg,
  output cra_pkg::sizes_t                sizes
);

  logic [cra_pkg::LEN_W-1:0] seg_c;

  always_comb begin
    sizes.fit_len = (cra_pkg::LEN_W'(req) +
      cra_pkg::LEN_W'(cra_pkg::CHUNK_HEADER_BYTES + cra_pkg::ALIGN_BYTES - 1)) &
      cra_pkg::ALIGN_MASK;
    sizes.keep_len = (cra_pkg::LEN_W'(req) +
      cra_pkg::LEN_W'(2 * cra_pkg::CHUNK_HEADER_BYTES + cra_pkg::ALIGN_BYTES - 1)) &
      cra_pkg::ALIGN_MASK;
    seg_c = (seg > cra_pkg::SEG_LIMIT) ? cra_pkg::SEG_LIMIT : seg;
    if (seg_c > cra_pkg::LEN_W'(cra_pkg::HEAD_OFF)) begin
      sizes.init_len = (seg_c - cra_pkg::LEN_W'(cra_pkg::HEAD_OFF)) & cra_pkg::ALIGN_MASK;
    end else begin
      sizes.init_len = '0;
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_coalescing_range_allocator_top.sv @@
// Self-checking testbench for the coalescing range allocator with a built-in allocation predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_coalescing_range_allocator_top;

  localparam logic [1:0] CMD_IDLE = 2'd3;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int LONG_HOLD = 400;
  localparam int NR = cra_pkg::MAX_RANGES;
  localparam int AB = cra_pkg::ADDR_BITS;
  localparam int LB = cra_pkg::LEN_W;
  localparam int TB = cra_pkg::TIME_W;
  localparam longint unsigned MASK25 = 64'h1FF_FFFF;
  localparam longint unsigned MASK32 = 64'hFFFF_FFFF;
  localparam longint unsigned MASK40 = 64'hFF_FFFF_FFFF;

  typedef struct {
    logic [1:0] status;
    logic [AB-1:0] offset;
    logic [LB-1:0] length;
    logic [LB-1:0] free_sum;
    logic [LB-1:0] used_sum;
    logic [LB-1:0] cool_sum;
    logic [cra_pkg::OVF_W-1:0] overflow;
    logic [TB-1:0] seq;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = CMD_IDLE;
  logic [cra_pkg::REQ_W-1:0] in_request_size = '0;
  logic [AB-1:0] in_chunk_offset = '0;
  logic [TB-1:0] in_now = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [AB-1:0] out_range_offset;
  logic [LB-1:0] out_range_length;
  logic [LB-1:0] out_free_total;
  logic [LB-1:0] out_used_total;
  logic [LB-1:0] out_cooling_total;
  logic [cra_pkg::OVF_W-1:0] out_overflow_total;
  logic [TB-1:0] out_change_sequence;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cra_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cra_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  coalescing_range_allocator_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the allocator state.
  longint unsigned seg_size, cool_time;
  longint unsigned fr_start[NR], fr_size[NR];
  longint unsigned us_start[NR], us_size[NR];
  longint unsigned cl_start[NR], cl_size[NR], cl_deadline[NR];
  int fr_count, us_count, cl_count;
  longint unsigned free_bytes, used_bytes, cool_bytes, ovf_bytes, seq_count;

  alloc_result_t pending_results[$];
  logic [AB-1:0] live_offsets[$];
  longint unsigned clock_now;
  int mismatches, results_seen, cycles;
  int status_seen[4];
  int hold_left;
  bit quiet;

  function automatic longint unsigned align_up(longint unsigned v);
    return ((v + cra_pkg::ALIGN_BYTES - 1) / cra_pkg::ALIGN_BYTES) * cra_pkg::ALIGN_BYTES;
  endfunction

  function automatic void rebuild_tables();
    longint unsigned seg, off, len;
    seg = (seg_size > (64'd1 << AB)) ? (64'd1 << AB) : seg_size;
    off = align_up(cra_pkg::HEAD_BYTES);
    len = (seg > off) ?
          ((seg - off) / cra_pkg::ALIGN_BYTES) * cra_pkg::ALIGN_BYTES : 0;
    fr_count = 0;
    if (len > 0) begin
      fr_start[0] = off;
      fr_size[0] = len;
      fr_count = 1;
    end
    us_count = 0;
    cl_count = 0;
    free_bytes = len;
    used_bytes = 0;
    cool_bytes = 0;
    ovf_bytes = 0;
    seq_count = 1;
    live_offsets.delete();
  endfunction

  function automatic void drop_free(int i);
    for (int k = i; k + 1 < fr_count; k++) begin
      fr_start[k] = fr_start[k+1];
      fr_size[k] = fr_size[k+1];
    end
    fr_count--;
  endfunction

  // Merges with neighbors until none is adjacent, then inserts by size if there is room.
  function automatic bit insert_free(longint unsigned s, longint unsigned l);
    bit merged;
    int i;
    merged = 1'b1;
    while (merged) begin
      merged = 1'b0;
      for (i = 0; i < fr_count; i++) begin
        if (fr_start[i] == s + l) begin
          l += fr_size[i];
          drop_free(i);
          merged = 1'b1;
          break;
        end
        if (s == fr_start[i] + fr_size[i]) begin
          s = fr_start[i];
          l += fr_size[i];
          drop_free(i);
          merged = 1'b1;
          break;
        end
      end
    end
    if (fr_count >= NR) return 1'b0;
    for (i = 0; i < fr_count; i++)
      if (fr_size[i] > l) break;
    for (int k = fr_count; k > i; k--) begin
      fr_start[k] = fr_start[k-1];
      fr_size[k] = fr_size[k-1];
    end
    fr_start[i] = s;
    fr_size[i] = l;
    fr_count++;
    return 1'b1;
  endfunction

  function automatic alloc_result_t predict_request(logic [1:0] cmd, longint unsigned req,
                                                    longint unsigned off, longint unsigned now);
    alloc_result_t r;
    longint unsigned l1, l2, s, l, r_off, r_len;
    logic [1:0] st;
    int i;
    st = cra_pkg::ST_OK;
    r_off = 0;
    r_len = 0;
    if (cmd == cra_pkg::CMD_ALLOC) begin
      l1 = align_up(req + cra_pkg::CHUNK_HEADER_BYTES);
      l2 = align_up(req + 2 * cra_pkg::CHUNK_HEADER_BYTES);
      if (us_count >= NR) st = cra_pkg::ST_FULL;
      else begin
        for (i = 0; i < fr_count; i++)
          if (fr_size[i] >= l1) break;
        if (i == fr_count) begin
          st = cra_pkg::ST_NO_SPACE;
          ovf_bytes += req;
          if (ovf_bytes > MASK40) ovf_bytes = MASK40;
        end else begin
          s = fr_start[i];
          l = fr_size[i];
          drop_free(i);
          if (l > l2) begin
            void'(insert_free(s + l1, l - l1));
            l = l1;
          end
          us_start[us_count] = s;
          us_size[us_count] = l;
          us_count++;
          free_bytes -= l;
          used_bytes += l;
          seq_count = (seq_count + 2) & MASK32;
          r_off = s;
          r_len = l;
          live_offsets.push_back(s[AB-1:0]);
        end
      end
    end else if (cmd == cra_pkg::CMD_FREE) begin
      for (i = 0; i < us_count; i++)
        if (us_start[i] == off) break;
      if (i == us_count) st = cra_pkg::ST_NOT_FOUND;
      else if (cl_count >= NR) st = cra_pkg::ST_FULL;
      else begin
        l = us_size[i];
        cl_start[cl_count] = us_start[i];
        cl_size[cl_count] = l;
        cl_deadline[cl_count] = (now + cool_time) & MASK32;
        cl_count++;
        us_count--;
        us_start[i] = us_start[us_count];
        us_size[i] = us_size[us_count];
        used_bytes -= l;
        cool_bytes += l;
        seq_count = (seq_count + 2) & MASK32;
        r_len = l;
        foreach (live_offsets[j])
          if (live_offsets[j] == off) begin
            live_offsets.delete(j);
            break;
          end
      end
    end else if (cmd == cra_pkg::CMD_CLEAN) begin
      while (cl_count > 0 && cl_deadline[0] <= now) begin
        s = cl_start[0];
        l = cl_size[0];
        if (!insert_free(s, l)) begin
          st = cra_pkg::ST_FULL;
          break;
        end
        for (int k = 0; k + 1 < cl_count; k++) begin
          cl_start[k] = cl_start[k+1];
          cl_size[k] = cl_size[k+1];
          cl_deadline[k] = cl_deadline[k+1];
        end
        cl_count--;
        free_bytes += l;
        cool_bytes -= l;
        r_len += l;
      end
      if (st != cra_pkg::ST_OK) r_len = 0;
    end
    r.status = st;
    r.offset = r_off[AB-1:0];
    r.length = r_len[LB-1:0];
    r.free_sum = free_bytes[LB-1:0];
    r.used_sum = used_bytes[LB-1:0];
    r.cool_sum = cool_bytes[LB-1:0];
    r.overflow = ovf_bytes[cra_pkg::OVF_W-1:0];
    r.seq = seq_count[TB-1:0];
    return r;
  endfunction

  function automatic int random_gap();
    int pick;
    pick = $urandom_range(99);
    if (quiet || pick < 60) return 0;
    if (pick < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // Offers one request and waits for the edge where it is taken; valid stays high unless a random gap follows.
  task automatic send_request(logic [1:0] cmd, longint unsigned req, longint unsigned off,
                              longint unsigned now);
    alloc_result_t r;
    int gap;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_request_size <= req[cra_pkg::REQ_W-1:0];
    in_chunk_offset <= off[AB-1:0];
    in_now <= now[TB-1:0];
    do @(posedge clk); while (in_stall);
    r = predict_request(cmd, req & 64'hFF_FFFF, off & 64'hFF_FFFF, now & MASK32);
    pending_results.push_back(r);
    gap = random_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [cra_pkg::CFG_IDX_W-1:0] idx, longint unsigned value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[cra_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == cra_pkg::CFG_SEGMENT_SIZE) begin
      seg_size = value & MASK25;
      rebuild_tables();
    end else if (idx == cra_pkg::CFG_COOL_TIME) begin
      cool_time = value & MASK32;
    end
  endtask

  // One random request; mostly well-formed allocate/free/clean traffic.
  task automatic send_random(int max_req);
    int pick;
    longint unsigned req;
    pick = $urandom_range(99);
    clock_now = (clock_now + $urandom_range(8)) & MASK32;
    if (pick < 42) begin
      req = ($urandom_range(19) == 0) ? $urandom() & 64'hFF_FFFF : $urandom_range(max_req);
      send_request(cra_pkg::CMD_ALLOC, req, $urandom(), clock_now);
    end else if (pick < 72 && live_offsets.size() > 0) begin
      send_request(cra_pkg::CMD_FREE, $urandom(),
                   live_offsets[$urandom_range(live_offsets.size() - 1)], clock_now);
    end else if (pick < 78) begin
      send_request(cra_pkg::CMD_FREE, $urandom(), $urandom(), clock_now);
    end else if (pick < 97) begin
      clock_now = (clock_now + $urandom_range(80)) & MASK32;
      send_request(cra_pkg::CMD_CLEAN, $urandom(), $urandom(), clock_now);
    end else begin
      send_request(CMD_IDLE, $urandom(), $urandom(), $urandom());
    end
  endtask

  task automatic test_reset_state();
    send_request(cra_pkg::CMD_CLEAN, 0, 0, 0);
    send_request(CMD_IDLE, 24'hFFFFFF, 24'hFFFFFF, MASK32);
    send_request(cra_pkg::CMD_FREE, 0, 24'h000040, 5);
  endtask

  task automatic test_alloc_extremes();
    send_request(cra_pkg::CMD_ALLOC, 0, 0, 10);
    send_request(cra_pkg::CMD_ALLOC, 1, 0, 10);
    send_request(cra_pkg::CMD_ALLOC, 24'hFFFFFF, 0, 10);
    send_request(cra_pkg::CMD_ALLOC, 1000, 0, 10);
    send_request(cra_pkg::CMD_ALLOC, 15, 0, 10);
    send_request(cra_pkg::CMD_FREE, 0, live_offsets[0], 20);
    send_request(cra_pkg::CMD_FREE, 0, 24'hFFFFFF, 20);
    send_request(cra_pkg::CMD_CLEAN, 0, 0, 79);
    send_request(cra_pkg::CMD_CLEAN, 0, 0, 80);
    send_request(cra_pkg::CMD_FREE, 0, live_offsets[0], MASK32);
    send_request(cra_pkg::CMD_CLEAN, 0, 0, MASK32);
  endtask

  // A tiny segment can grant one range whole; an empty one grants nothing.
  task automatic test_segment_extremes();
    write_register(cra_pkg::CFG_SEGMENT_SIZE, 0);
    send_request(cra_pkg::CMD_ALLOC, 0, 0, 0);
    write_register(cra_pkg::CFG_SEGMENT_SIZE, 64 + 80);
    send_request(cra_pkg::CMD_ALLOC, 0, 0, 0);
    send_request(cra_pkg::CMD_ALLOC, 0, 0, 0);
    write_register(cra_pkg::CFG_SEGMENT_SIZE, MASK25);
    send_request(cra_pkg::CMD_ALLOC, 24'hFFFFFF, 0, 0);
    send_request(cra_pkg::CMD_ALLOC, 24'hFFFF00, 0, 0);
    write_register(cra_pkg::CFG_SEGMENT_SIZE, 64'd1 << AB);
    send_request(cra_pkg::CMD_ALLOC, 24'hFFFF00, 0, 0);
  endtask

  task automatic test_tables_full();
    write_register(cra_pkg::CFG_SEGMENT_SIZE, 1048576);
    write_register(cra_pkg::CFG_COOL_TIME, MASK32);
    for (int i = 0; i < NR + 2; i++) send_request(cra_pkg::CMD_ALLOC, 32 * i, 0, 0);
    for (int i = 0; i < NR; i++) send_request(cra_pkg::CMD_FREE, 0, live_offsets[0], 1);
    send_request(cra_pkg::CMD_ALLOC, 100, 0, 2);
    send_request(cra_pkg::CMD_FREE, 0, live_offsets[0], 2);
    send_request(cra_pkg::CMD_CLEAN, 0, 0, MASK32 - 1);
    send_request(cra_pkg::CMD_CLEAN, 0, 0, 0);
  endtask

  // The receiver holds off long enough for the input side to back up.
  task automatic test_backpressure();
    write_register(cra_pkg::CFG_COOL_TIME, 0);
    hold_left = LONG_HOLD;
    repeat (12) send_random(3000);
    wait_drained();
    repeat (6) send_random(3000);
  endtask

  task automatic test_random(int count);
    longint unsigned cool_set[4];
    longint unsigned seg_set[4];
    cool_set = '{0, 60, 200, MASK32};
    seg_set = '{1048576, 65536, 8192, 64'd1 << AB};
    for (int p = 0; p < 8; p++) begin
      write_register(cra_pkg::CFG_SEGMENT_SIZE, seg_set[p % 4]);
      write_register(cra_pkg::CFG_COOL_TIME, cool_set[$urandom_range(3)]);
      quiet = (p % 3 == 1);
      if (p == 5) clock_now = MASK32 - 2000;
      for (int i = 0; i < count / 8; i++) send_random(p == 3 ? 200000 : 3000);
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 25 || $urandom_range(199) == 0);
      end
    end
  end

  always @(posedge clk) begin
    alloc_result_t w;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result status", out_status, 0);
      end else begin
        w = pending_results.pop_front();
        status_seen[w.status]++;
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_range_offset !== w.offset)
          report_mismatch("range_offset", out_range_offset, w.offset);
        if (out_range_length !== w.length)
          report_mismatch("range_length", out_range_length, w.length);
        if (out_free_total !== w.free_sum)
          report_mismatch("free_total", out_free_total, w.free_sum);
        if (out_used_total !== w.used_sum)
          report_mismatch("used_total", out_used_total, w.used_sum);
        if (out_cooling_total !== w.cool_sum)
          report_mismatch("cooling_total", out_cooling_total, w.cool_sum);
        if (out_overflow_total !== w.overflow)
          report_mismatch("overflow_total", out_overflow_total, w.overflow);
        if (out_change_sequence !== w.seq)
          report_mismatch("change_sequence", out_change_sequence, w.seq);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    seg_size = 1048576;
    cool_time = 60;
    rebuild_tables();
    clock_now = 0;
    hold_left = 0;
    quiet = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_alloc_extremes();
    test_segment_extremes();
    test_tables_full();
    test_backpressure();
    test_random(1600);
    wait_drained();
    $display("Covered %0d results: %0d ok, %0d no space, %0d not found, %0d table full,",
             results_seen, status_seen[cra_pkg::ST_OK], status_seen[cra_pkg::ST_NO_SPACE],
             status_seen[cra_pkg::ST_NOT_FOUND], status_seen[cra_pkg::ST_FULL]);
    $display("over several segment sizes and cooling times with random stalls.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/cra_pkg.sv
rtl/cra_sizes.sv
rtl/coalescing_range_allocator_top.sv
tb/tb_coalescing_range_allocator_top.sv
